// ===== hdl/crds_pkg.sv =====
package crds_pkg;

    localparam int ROM_WORDS   = 256;
    localparam int ROM_AW      = $clog2(ROM_WORDS);
    localparam int IDX_W       = ROM_AW + 1;
    localparam int STACK_DEPTH = 16;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int CNT_W       = STACK_AW + 1;
    localparam int INFO_WORDS  = 5;

    localparam logic [31:0] ROOT_REF = 32'hc000_0005;
    localparam logic [47:0] ROM_BASE = 48'hffff_f000_0400;
    localparam logic [1:0]  DIR_TYPE = 2'd3;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_RESP  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [2:0] ST_REQ  = 3'd0;
    localparam logic [2:0] ST_DONE = 3'd1;
    localparam logic [2:0] ST_FAIL = 3'd2;
    localparam logic [2:0] ST_DATA = 3'd3;
    localparam logic [2:0] ST_IGN  = 3'd4;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_INFO = 2'd1;
    localparam logic [1:0] PH_HEAD = 2'd2;
    localparam logic [1:0] PH_BODY = 2'd3;

    typedef struct packed {
        logic [1:0]       phase;
        logic [CNT_W-1:0] stack_count;
        logic [IDX_W-1:0] cur_index;
        logic [IDX_W-1:0] block_end;
        logic [31:0]      cur_ref;
        logic [IDX_W-1:0] max_length;
    } t_state;

    typedef struct packed {
        logic [1:0]  cmd;
        logic        response_ok;
        logic [31:0] quadlet;
    } t_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  request_index;
        logic [47:0] request_address;
        logic [8:0]  rom_length;
        logic [31:0] data;
    } t_result;

    typedef struct packed {
        logic                rom_we;
        logic [ROM_AW-1:0]   rom_addr;
        logic [31:0]         rom_data;
        logic                stk_we;
        logic [STACK_AW-1:0] stk_addr;
        logic [31:0]         stk_data;
    } t_mem_wr;

endpackage

// ===== hdl/crds_step.sv =====
module crds_step
    import crds_pkg::*;
(
    input  t_state  i_state,
    input  t_item   i_item,
    input  logic [31:0] i_stk_rd,
    input  logic [31:0] i_rom_rd,
    output t_state  o_state,
    output t_result o_result,
    output t_mem_wr o_wr
);

    logic [IDX_W-1:0] nxt_idx;
    logic [17:0]      head_end;
    logic             do_end;
    logic             do_next;
    logic [31:0]      top_ref;
    logic [31:0]      push_val;
    logic             push_ok;

    always_comb begin
        nxt_idx  = i_state.cur_index + IDX_W'(1);
        head_end = 18'(i_state.cur_index) + 18'(i_item.quadlet[31:16]) + 18'd1;
        push_val = i_item.quadlet + 32'(i_state.cur_index);
        push_ok  = (i_state.cur_ref[31:30] == DIR_TYPE) && (i_item.quadlet[31:30] > 2'd1)
                   && (i_state.stack_count < CNT_W'(STACK_DEPTH));

        o_state  = i_state;
        o_result = '0;
        o_result.status = ST_IGN;
        o_wr     = '0;
        do_end   = 1'b0;
        do_next  = 1'b0;
        top_ref  = i_stk_rd;

        unique case (i_item.cmd)
            CMD_START: begin
                o_state       = '0;
                o_state.phase = PH_INFO;
                o_result.status = ST_REQ;
            end
            CMD_RESP: begin
                if (i_state.phase == PH_IDLE) begin
                    o_result.status = ST_IGN;
                end else if (!i_item.response_ok || i_state.cur_index[IDX_W-1]) begin
                    o_state.phase   = PH_IDLE;
                    o_result.status = ST_FAIL;
                end else begin
                    o_wr.rom_we   = 1'b1;
                    o_wr.rom_addr = i_state.cur_index[ROM_AW-1:0];
                    o_wr.rom_data = i_item.quadlet;
                    unique case (i_state.phase)
                        PH_INFO: begin
                            if (i_state.cur_index == '0 && i_item.quadlet == '0) begin
                                o_state.phase   = PH_IDLE;
                                o_result.status = ST_FAIL;
                            end else begin
                                o_state.cur_index = nxt_idx;
                                if (nxt_idx < IDX_W'(INFO_WORDS)) begin
                                    o_result.status        = ST_REQ;
                                    o_result.request_index = 8'(nxt_idx);
                                end else begin
                                    o_state.max_length  = nxt_idx;
                                    o_state.stack_count = CNT_W'(1);
                                    top_ref = ROOT_REF;
                                    do_next = 1'b1;
                                end
                            end
                        end
                        PH_HEAD: begin
                            if (head_end > 18'(ROM_WORDS)) begin
                                o_state.phase   = PH_IDLE;
                                o_result.status = ST_FAIL;
                            end else begin
                                o_state.block_end = head_end[IDX_W-1:0];
                                o_state.cur_index = nxt_idx;
                                if (18'(nxt_idx) < head_end) begin
                                    o_state.phase          = PH_BODY;
                                    o_result.status        = ST_REQ;
                                    o_result.request_index = 8'(nxt_idx);
                                end else begin
                                    do_end = 1'b1;
                                end
                            end
                        end
                        PH_BODY: begin
                            if (push_ok) begin
                                o_wr.stk_we   = 1'b1;
                                o_wr.stk_addr = i_state.stack_count[STACK_AW-1:0];
                                o_wr.stk_data = push_val;
                                o_state.stack_count = i_state.stack_count + CNT_W'(1);
                                top_ref = push_val;
                            end
                            o_state.cur_index = nxt_idx;
                            if (nxt_idx < i_state.block_end) begin
                                o_result.status        = ST_REQ;
                                o_result.request_index = 8'(nxt_idx);
                            end else begin
                                do_end = 1'b1;
                            end
                        end
                        default: begin
                            o_result.status = ST_IGN;
                        end
                    endcase
                end
            end
            CMD_READ: begin
                o_result.status = ST_DATA;
                o_result.data   = i_rom_rd;
            end
            default: begin
                o_result.status = ST_IGN;
            end
        endcase

        if (do_end && o_state.max_length < o_state.cur_index) begin
            o_state.max_length = o_state.cur_index;
        end

        if (do_end || do_next) begin
            if (o_state.stack_count == '0) begin
                o_state.phase       = PH_IDLE;
                o_result.status     = ST_DONE;
                o_result.rom_length = 9'(o_state.max_length);
            end else begin
                o_state.stack_count = o_state.stack_count - CNT_W'(1);
                o_state.cur_ref     = top_ref;
                if (top_ref[23:0] >= 24'(ROM_WORDS)) begin
                    o_state.phase   = PH_IDLE;
                    o_result.status = ST_FAIL;
                end else begin
                    o_state.cur_index      = top_ref[IDX_W-1:0];
                    o_state.phase          = PH_HEAD;
                    o_result.status        = ST_REQ;
                    o_result.request_index = 8'(top_ref[ROM_AW-1:0]);
                end
            end
        end

        if (o_result.status == ST_REQ) begin
            o_result.request_address = ROM_BASE + {38'd0, o_result.request_index, 2'b00};
        end
    end

endmodule

// ===== hdl/config_rom_directory_scanner.sv =====
// The item and its memory reads are registered at the transfer, and the result is
// registered once the output register is free or taken. A new item is accepted only
// after the last completes; stack and quadlet writes land then, before the next read.
// Reset (synchronous, active low): scan idle, stack empty, pipeline and output empty.
// Quadlet and reference memories are not cleared.
module config_rom_directory_scanner
    import crds_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic        i_response_ok,
    input  logic [31:0] i_quadlet,
    input  logic [7:0]  i_read_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [7:0]  o_request_index,
    output logic [47:0] o_request_address,
    output logic [8:0]  o_rom_length,
    output logic [31:0] o_data
);

    logic [31:0] r_rom [ROM_WORDS];
    logic [31:0] r_stk [STACK_DEPTH];

    logic        r_s2_valid;
    t_item       r_item;
    t_state      r_state;
    logic [31:0] r_stk_rd;
    logic [31:0] r_rom_rd;
    logic        r_out_valid;
    t_result     r_out;

    t_state  n_state;
    t_result n_out;
    t_mem_wr n_wr;

    logic in_xfer;
    logic s2_done;

    assign o_ready = !r_s2_valid;
    assign in_xfer = i_valid && o_ready;
    assign s2_done = r_s2_valid && (!r_out_valid || i_ready);

    crds_step u_step (
        .i_state  (r_state),
        .i_item   (r_item),
        .i_stk_rd (r_stk_rd),
        .i_rom_rd (r_rom_rd),
        .o_state  (n_state),
        .o_result (n_out),
        .o_wr     (n_wr)
    );

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_rom_rd <= r_rom[i_read_index[ROM_AW-1:0]];
            r_stk_rd <= r_stk[STACK_AW'(r_state.stack_count - CNT_W'(1))];
            r_item   <= '{cmd: i_cmd, response_ok: i_response_ok, quadlet: i_quadlet};
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_done && n_wr.rom_we) begin
            r_rom[n_wr.rom_addr] <= n_wr.rom_data;
        end
        if (s2_done && n_wr.stk_we) begin
            r_stk[n_wr.stk_addr] <= n_wr.stk_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (in_xfer) begin
                r_s2_valid <= 1'b1;
            end else if (s2_done) begin
                r_s2_valid <= 1'b0;
            end
            if (s2_done) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_done) begin
            r_out <= n_out;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_status          = r_out.status;
    assign o_request_index   = r_out.request_index;
    assign o_request_address = r_out.request_address;
    assign o_rom_length      = r_out.rom_length;
    assign o_data            = r_out.data;

    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.stack_count <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_interlock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_s2_valid && !o_ready))
        else $error("transfer not held for update cycle");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase != PH_IDLE) |-> (r_state.cur_index < IDX_W'(ROM_WORDS)))
        else $error("scan index out of range");

    a_done_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_done && n_out.status == ST_DONE)
            |-> (n_out.rom_length >= 9'(INFO_WORDS) && n_out.rom_length <= 9'(ROM_WORDS)))
        else $error("done with bad length");

endmodule
